// File: rtl/ssbf_pkg.sv
// Shared constants and types for the seven-bit sample framer.
`timescale 1ns / 1ps
package ssbf_pkg;

  localparam int SAMPLE_W   = 16;  // width of the sample field on the input channel
  localparam int MODE_W     = 7;
  localparam int LEFT_W     = 6;   // most pending payload bits kept between items
  localparam int GROUP_BITS = 7;   // payload bits per data byte
  localparam int BYTE_W     = 8;
  localparam int Q_DEPTH    = 2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_EOF    = 1'b1;

  localparam logic [BYTE_W-1:0] CMD_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_STOP  = 8'h81;
  localparam logic [BYTE_W-1:0] EDGE_BYTE = 8'h82;
  localparam logic [MODE_W-1:0] EDGE_MODE = 7'd1;

  // Register select bit of paddr (byte address 4*i).
  localparam logic ADDR_MODE_REG = 1'b0;

  typedef struct packed {
    logic need_trig;  // frame not open yet: send the trigger byte first
    logic eof;        // end-of-frame job: stop byte (and edge byte) follow
  } job_ctl_t;

  localparam int JOB_CTL_W = $bits(job_ctl_t);

endpackage

// File: rtl/ssbf_in_if.sv
// Input channel: sample words and end-of-frame requests.
`timescale 1ns / 1ps
interface ssbf_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] sample_word;

  modport source (output valid, output req_type, output sample_word, input ready);
  modport sink   (input valid, input req_type, input sample_word, output ready);
endinterface

// File: rtl/ssbf_out_if.sv
// Output channel: wire bytes with an end-of-run marker.
`timescale 1ns / 1ps
interface ssbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/sample_seven_bit_framer.sv
// Top level of the seven-bit sample framer: register port, front, queue, back.
//
//   channel  direction  transfer condition          payload
//   in_ch    input      valid & ready               req_type, sample_word
//   out_ch   output     valid & ready               out_byte, last_of_run
//   config   input      psel & penable & pwrite     mode register at paddr 0
//
// One byte leaves per cycle from the output register while the link is ready;
// a 16-bit sample makes 2 or 3 data bytes, plus the trigger byte at frame start,
// and an end of frame makes 1 to 3 bytes; the link sets the rate.
// rst_n is synchronous; after reset no frame is open and no bits are pending.
// The front takes a new item whenever the two-entry job queue has room, so
// output stalls reach the input only once the queue fills.
`timescale 1ns / 1ps
module sample_seven_bit_framer #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ssbf_in_if.sink     in_ch,
  ssbf_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssbf_pkg::*;

  localparam int ACC_W = SAMPLE_BITS + LEFT_W;
  localparam int CNT_W = $clog2(SAMPLE_BITS + GROUP_BITS);
  localparam int JOB_W = JOB_CTL_W + CNT_W + ACC_W;

  logic [MODE_W-1:0] mode_r;
  logic              cfg_wr;

  logic             push, pop, q_full, q_valid;
  job_ctl_t         f_ctl, b_ctl;
  logic [ACC_W-1:0] f_acc, b_acc;
  logic [CNT_W-1:0] f_cnt, b_cnt;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ADDR_MODE_REG) ? 32'(mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else if (cfg_wr && paddr[2] == ADDR_MODE_REG) begin
      mode_r <= pwdata[MODE_W-1:0];
    end
  end

  ssbf_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .push    (push),
    .job_ctl (f_ctl),
    .job_acc (f_acc),
    .job_cnt (f_cnt)
  );

  assign q_wdata = {f_ctl, f_cnt, f_acc};

  ssbf_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wdata    (q_wdata),
    .pop      (pop),
    .rdata    (q_rdata),
    .full     (q_full),
    .nonempty (q_valid)
  );

  assign {b_ctl, b_cnt, b_acc} = q_rdata;

  ssbf_back #(
    .ACC_W (ACC_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .job_ctl  (b_ctl),
    .job_acc  (b_acc),
    .job_cnt  (b_cnt),
    .mode_cfg (mode_r),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // an accepted item is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> q_valid)
    else $error("accepted item missing from job queue");

  // outside edge mode the stop byte always closes its run
  a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.out_byte == CMD_STOP && mode_r != EDGE_MODE)
      |-> out_ch.last_of_run)
    else $error("stop byte not marked last");

  // the back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty job queue");

endmodule

// File: rtl/ssbf_front.sv
// Front end: accepts items, tracks frame and leftover bits, builds byte jobs.
`timescale 1ns / 1ps
module ssbf_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = 22,
  parameter int CNT_W       = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  ssbf_in_if.sink             in_ch,
  input  logic                q_full,
  output logic                push,
  output ssbf_pkg::job_ctl_t  job_ctl,
  output logic [ACC_W-1:0]    job_acc,
  output logic [CNT_W-1:0]    job_cnt
);
  import ssbf_pkg::*;

  localparam int SB_MOD = SAMPLE_BITS % GROUP_BITS;

  logic              open_r, open_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [2:0]        lcnt_r, lcnt_nxt;

  logic [SAMPLE_BITS-1:0] samp;
  logic [ACC_W-1:0]       acc_s;
  logic [3:0]             csum;
  logic [2:0]             ncnt;
  logic [LEFT_W-1:0]      nleft;
  logic [GROUP_BITS-1:0]  flush;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign samp  = SAMPLE_BITS'(in_ch.sample_word);
  assign acc_s = {left_r, samp};

  // (lcnt + SAMPLE_BITS) mod 7, with the constant part folded in
  assign csum  = 4'(lcnt_r) + 4'(SB_MOD);
  assign ncnt  = (csum >= 4'(GROUP_BITS)) ? 3'(csum - 4'(GROUP_BITS)) : csum[2:0];
  assign nleft = acc_s[LEFT_W-1:0] & LEFT_W'((7'd1 << ncnt) - 7'd1);

  // pending bits left-aligned in a 7-bit group, zero padded
  assign flush = GROUP_BITS'({1'b0, left_r} << (3'd7 - lcnt_r));

  always_comb begin
    job_ctl.need_trig = !open_r;
    job_ctl.eof       = (in_ch.req_type == REQ_EOF);
    open_nxt          = open_r;
    left_nxt          = left_r;
    lcnt_nxt          = lcnt_r;
    if (in_ch.req_type == REQ_EOF) begin
      job_acc = ACC_W'(flush);
      job_cnt = (lcnt_r != 3'd0) ? CNT_W'(GROUP_BITS) : '0;
    end else begin
      job_acc = acc_s;
      job_cnt = CNT_W'(lcnt_r) + CNT_W'(SAMPLE_BITS);
    end
    if (push) begin
      if (in_ch.req_type == REQ_EOF) begin
        open_nxt = 1'b0;
        left_nxt = '0;
        lcnt_nxt = '0;
      end else begin
        open_nxt = 1'b1;
        left_nxt = nleft;
        lcnt_nxt = ncnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= '0;
      lcnt_r <= '0;
    end else begin
      open_r <= open_nxt;
      left_r <= left_nxt;
      lcnt_r <= lcnt_nxt;
    end
  end

endmodule

// File: rtl/ssbf_queue.sv
// Two-entry job queue between front and back end.
`timescale 1ns / 1ps
module ssbf_queue #(
  parameter int W = 29
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         nonempty
);
  import ssbf_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [W-1:0]     mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// File: rtl/ssbf_back.sv
// Back end: walks one job at a time and emits one byte per cycle while the output is not stalled.
`timescale 1ns / 1ps
module ssbf_back #(
  parameter int ACC_W = 22,
  parameter int CNT_W = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  ssbf_pkg::job_ctl_t             job_ctl,
  input  logic [ACC_W-1:0]               job_acc,
  input  logic [CNT_W-1:0]               job_cnt,
  input  logic [ssbf_pkg::MODE_W-1:0]    mode_cfg,
  output logic                           pop,
  ssbf_out_if.source                     out_ch
);
  import ssbf_pkg::*;

  logic             trig_r, trig_nxt;
  logic             stop_r, stop_nxt;
  logic             edge_r, edge_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic              busy, slot_free, emit, last;
  logic [BYTE_W-1:0] byte_val;
  logic [ACC_W-1:0]  shifted;

  assign busy      = trig_r || (cnt_r >= CNT_W'(GROUP_BITS)) || stop_r || edge_r;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit      = busy && slot_free;
  assign shifted   = acc_r >> (cnt_r - CNT_W'(GROUP_BITS));

  always_comb begin
    trig_nxt = trig_r;
    stop_nxt = stop_r;
    edge_nxt = edge_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    byte_val = EDGE_BYTE;
    if (emit) begin
      priority if (trig_r) begin
        byte_val = CMD_BIT | BYTE_W'(mode_cfg);
        trig_nxt = 1'b0;
      end else if (cnt_r >= CNT_W'(GROUP_BITS)) begin
        byte_val = {1'b0, shifted[GROUP_BITS-1:0]};
        cnt_nxt  = cnt_r - CNT_W'(GROUP_BITS);
      end else if (stop_r) begin
        byte_val = CMD_STOP;
        stop_nxt = 1'b0;
      end else begin
        byte_val = EDGE_BYTE;
        edge_nxt = 1'b0;
      end
    end
    last = !(trig_nxt || (cnt_nxt >= CNT_W'(GROUP_BITS)) || stop_nxt || edge_nxt);
    // next job loads as the current one hands over its final byte
    pop  = q_valid && (!busy || (emit && last));
    if (pop) begin
      trig_nxt = job_ctl.need_trig;
      stop_nxt = job_ctl.eof;
      edge_nxt = job_ctl.eof && (mode_cfg == EDGE_MODE);
      cnt_nxt  = job_cnt;
      acc_nxt  = job_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r      <= 1'b0;
      stop_r      <= 1'b0;
      edge_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      trig_r <= trig_nxt;
      stop_r <= stop_nxt;
      edge_r <= edge_nxt;
      cnt_r  <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (emit) begin
      out_byte_r <= byte_val;
      out_last_r <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

// File: tb/sv/tb_sample_seven_bit_framer.sv
// Self-checking testbench for the seven-bit sample framer.
`timescale 1ns / 1ps
module tb_sample_seven_bit_framer;
  import ssbf_pkg::*;

  localparam int          IDLE_LIMIT     = 4000;  // cycles with no transfer before giving up
  localparam logic [2:0]  TRIG_MODE_ADDR = {ADDR_MODE_REG, 2'b00};

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample_word;
  } framer_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } wire_byte_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ssbf_in_if  in_ch();
  ssbf_out_if out_ch();

  sample_seven_bit_framer u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  framer_item_t pending_items[$];
  wire_byte_t   wire_bytes_due[$];

  // shadow of the framer state and its register
  logic              shadow_frame_open;
  logic [LEFT_W-1:0] shadow_left_bits;
  int                shadow_left_cnt;
  logic [MODE_W-1:0] shadow_trig_mode;

  int        error_count = 0;
  int        idle_cycles = 0;
  int        samples_sent = 0;
  int        eofs_sent = 0;
  int        bytes_checked = 0;
  int        modes_used = 0;
  rx_style_t rx_style = RX_OPEN;
  int        tx_gap_max = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        rx_hold = 0;
  int        cyc = 0;
  framer_item_t next_item;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    wire_byte_t wb;
    wb.out_byte = b;
    wb.last_of_run = 1'b0;
    wire_bytes_due.push_back(wb);
  endtask

  // Works out the bytes one accepted item causes and queues them.
  task automatic frame_item(input framer_item_t it);
    logic [LEFT_W+SAMPLE_W-1:0] acc;
    int                         total;
    int                         first;
    wire_byte_t                 tail;
    first = wire_bytes_due.size();
    if (!shadow_frame_open) begin
      push_byte(CMD_BIT | BYTE_W'(shadow_trig_mode));
      shadow_frame_open = 1'b1;
    end
    if (it.req_type == REQ_SAMPLE) begin
      acc = {shadow_left_bits, it.sample_word};
      total = shadow_left_cnt + SAMPLE_W;
      while (total >= GROUP_BITS) begin
        push_byte(BYTE_W'((acc >> (total - GROUP_BITS)) & 'h7F));
        total -= GROUP_BITS;
      end
      shadow_left_bits = LEFT_W'(acc & ((1 << total) - 1));
      shadow_left_cnt = total;
    end else begin
      // partial group goes out zero-padded at the low end
      if (shadow_left_cnt > 0)
        push_byte(BYTE_W'((shadow_left_bits << (GROUP_BITS - shadow_left_cnt)) & 'h7F));
      push_byte(CMD_STOP);
      if (shadow_trig_mode == EDGE_MODE)
        push_byte(EDGE_BYTE);
      shadow_frame_open = 1'b0;
      shadow_left_bits = '0;
      shadow_left_cnt = 0;
    end
    if (wire_bytes_due.size() > first) begin
      tail = wire_bytes_due.pop_back();
      tail.last_of_run = 1'b1;
      wire_bytes_due.push_back(tail);
    end
  endtask

  // input driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.req_type <= REQ_SAMPLE;
      in_ch.sample_word <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0)
          gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        next_item = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.req_type <= next_item.req_type;
        in_ch.sample_word <= next_item.sample_word;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 7);
          gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        end
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    cyc++;
    case (rx_style)
      RX_OPEN: begin
        out_ch.ready <= 1'b1;
      end
      RX_RANDOM: begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      RX_PERIODIC: begin
        out_ch.ready <= ((cyc % 7) >= 3);
      end
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_hold = $urandom_range(1, 12);
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    wire_byte_t want;
    if (rst_n) begin
      idle_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        frame_item('{in_ch.req_type, in_ch.sample_word});
        idle_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        if (wire_bytes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h", out_ch.out_byte));
        end else begin
          want = wire_bytes_due.pop_front();
          bytes_checked++;
          if (out_ch.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %02h, want %02h", out_ch.out_byte, want.out_byte));
          if (out_ch.last_of_run !== want.last_of_run)
            flag_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
                                    out_ch.last_of_run, want.last_of_run, want.out_byte));
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles, %0d bytes outstanding",
             IDLE_LIMIT, wire_bytes_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic add_item(input logic req, input logic [SAMPLE_W-1:0] word);
    pending_items.push_back('{req, word});
    if (req == REQ_SAMPLE)
      samples_sent++;
    else
      eofs_sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // mostly complete frames, some stray items
  task automatic add_random_items(input int n);
    int added;
    int len;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(0, 9);
        repeat (len) add_item(REQ_SAMPLE, rand_sample());
        add_item(REQ_EOF, SAMPLE_W'($urandom));
        added += len + 1;
      end else begin
        add_item(logic'($urandom_range(0, 1)), rand_sample());
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || wire_bytes_due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode_reg(input logic [MODE_W-1:0] mode);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TRIG_MODE_ADDR;
    pwdata <= 32'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_trig_mode = mode;
    modes_used++;
    // read it back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(mode))
      flag_mismatch($sformatf("mode register reads %08h, want %02h", prdata, mode));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [MODE_W-1:0] mode, input rx_style_t style,
                                  input int gap_max);
    write_mode_reg(mode);
    rx_style = style;
    tx_gap_max = gap_max;
    add_random_items(40);
    wait_drained();
  endtask

  initial begin
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    shadow_frame_open = 1'b0;
    shadow_left_bits = '0;
    shadow_left_cnt = 0;
    shadow_trig_mode = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset mode: extremes, padded flush, empty frame, all leftover counts
    tx_gap_max = 3;
    rx_style = RX_RANDOM;
    add_item(REQ_SAMPLE, 16'h0000);
    add_item(REQ_SAMPLE, 16'hFFFF);
    add_item(REQ_EOF, 16'hFFFF);
    add_item(REQ_EOF, 16'h0000);
    add_item(REQ_SAMPLE, 16'h8000);
    add_item(REQ_SAMPLE, 16'h0001);
    add_item(REQ_SAMPLE, 16'hAAAA);
    add_item(REQ_SAMPLE, 16'h5555);
    add_item(REQ_SAMPLE, 16'h1234);
    add_item(REQ_SAMPLE, 16'hFEDC);
    add_item(REQ_SAMPLE, 16'h7FFF);
    add_item(REQ_EOF, 16'h0000);  // no bits pending here
    wait_drained();

    // edge mode adds the edge-reset byte
    write_mode_reg(EDGE_MODE);
    add_item(REQ_SAMPLE, 16'hFFFF);
    add_item(REQ_EOF, 16'h0000);
    add_item(REQ_EOF, 16'h0000);
    add_item(REQ_SAMPLE, 16'h0F0F);
    add_item(REQ_SAMPLE, 16'hF0F0);
    add_item(REQ_SAMPLE, 16'hC3C3);
    add_item(REQ_EOF, 16'hFFFF);
    wait_drained();

    write_mode_reg(7'h7F);
    add_item(REQ_SAMPLE, 16'h0000);
    add_item(REQ_EOF, 16'h0000);
    add_item(REQ_EOF, 16'h0000);
    wait_drained();

    run_random_phase(7'd0, RX_OPEN, 0);
    run_random_phase(EDGE_MODE, RX_RANDOM, 4);
    run_random_phase(7'h7F, RX_BURSTY, 2);
    run_random_phase(7'h55, RX_PERIODIC, 6);
    run_random_phase(EDGE_MODE, RX_BURSTY, 0);
    run_random_phase(7'h2A, RX_RANDOM, 8);
    run_random_phase(MODE_W'($urandom_range(2, 126)), RX_PERIODIC, 1);

    repeat (20) @(posedge clk);
    $display("covered %0d sample items and %0d end-of-frame items over %0d mode writes",
             samples_sent, eofs_sent, modes_used);
    $display("checked %0d output bytes, %0d mismatches", bytes_checked, error_count);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ssbf_pkg.sv
rtl/ssbf_in_if.sv
rtl/ssbf_out_if.sv
rtl/ssbf_front.sv
rtl/ssbf_queue.sv
rtl/ssbf_back.sv
rtl/sample_seven_bit_framer.sv
tb/sv/tb_sample_seven_bit_framer.sv
